// ----- sv/pu_pkg.sv -----
// pu_pkg: shared constants and types for the permutation unranking block.
// No dependencies. Used by pu_front, pu_queue, pu_back and permutation_unranking.
package pu_pkg;

    localparam int MAX_SET   = 20;
    localparam int CNT_W     = 5;                  // set size, pick length, element, position
    localparam int RANK_W    = 62;
    localparam int IDX_W     = $clog2(MAX_SET);    // unused-list / block-table index
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PICK_LENGTH = CFG_IDX_W'(1);

    // one classified job handed from front to back
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [CNT_W-1:0]  n;
        logic [CNT_W-1:0]  r;
        logic              err;
    } t_job;

endpackage

// ----- sv/pu_front.sv -----
// pu_front: accepts a rank, builds the falling factorial n!/(n-r)! one factor
// per cycle and flags ranks at or above it. Depends on pu_pkg.
module pu_front import pu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [RANK_W-1:0] i_rank,
    input  logic [CNT_W-1:0]  i_n,
    input  logic [CNT_W-1:0]  i_r,
    output logic              o_full,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_job              o_q_job
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate                   r_state, n_state;
    logic [RANK_W-1:0]         r_rank;
    logic [RANK_W-1:0]         r_acc;
    logic [CNT_W-1:0]          r_n;
    logic [CNT_W-1:0]          r_r;
    logic [CNT_W-1:0]          r_k;
    logic [RANK_W+CNT_W-1:0]   prod;

    assign prod = r_acc * (r_n - r_k);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_push) n_state = F_MUL;
            F_MUL:  if (r_k == r_r - CNT_W'(1)) n_state = F_PUSH;
            F_PUSH: if (!i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_push) begin
            r_rank <= i_rank;
            r_n    <= i_n;
            r_r    <= i_r;
            r_acc  <= RANK_W'(1);
            r_k    <= '0;
        end else if (r_state == F_MUL) begin
            r_acc <= prod[RANK_W-1:0];
            r_k   <= r_k + CNT_W'(1);
        end
    end

    assign o_full       = (r_state != F_IDLE);
    assign o_q_push     = (r_state == F_PUSH) && !i_q_full;
    assign o_q_job.rank = r_rank;
    assign o_q_job.n    = r_n;
    assign o_q_job.r    = r_r;
    assign o_q_job.err  = (r_rank >= r_acc);

endmodule

// ----- sv/pu_queue.sv -----
// pu_queue: two-entry job queue between front and back.
// Depends on pu_pkg.
module pu_queue import pu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_job;
    end

endmodule

// ----- sv/pu_back.sv -----
// pu_back: unranks one job: builds the block-count table, then per position
// finds the digit by repeated subtraction and pulls the element from the
// unused list. Holds the output register. Depends on pu_pkg.
module pu_back import pu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  t_job             i_job,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [CNT_W-1:0] o_element,
    output logic [CNT_W-1:0] o_position,
    output logic             o_last,
    output logic             o_range_error
);

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_BUILD = 5'b00010,
        B_READ  = 5'b00100,
        B_DIG   = 5'b01000,
        B_ERR   = 5'b10000
    } t_bstate;

    t_bstate                 r_state, n_state;
    logic [RANK_W-1:0]       r_blk_mem [MAX_SET];
    logic [RANK_W-1:0]       r_blk;
    logic [RANK_W-1:0]       r_rem;
    logic [RANK_W-1:0]       r_acc;
    logic [CNT_W-1:0]        r_n;
    logic [CNT_W-1:0]        r_r;
    logic [IDX_W-1:0]        r_k;
    logic [CNT_W-1:0]        r_pos;
    logic [IDX_W-1:0]        r_digit;
    logic [CNT_W-1:0]        r_list [MAX_SET];
    logic                    r_out_valid;
    logic [CNT_W-1:0]        r_elem;
    logic [CNT_W-1:0]        r_opos;
    logic                    r_last;
    logic                    r_err;

    logic [RANK_W+CNT_W-1:0] prod;
    logic [CNT_W-1:0]        left;
    logic                    take;
    logic                    out_can;
    logic                    start;
    logic                    emit;
    logic                    is_last;

    assign prod    = r_acc * (r_n - CNT_W'(r_k));
    assign left    = r_n - r_pos;
    assign take    = (r_rem >= r_blk) && (CNT_W'(r_digit) < left - CNT_W'(1));
    assign out_can = !r_out_valid || i_pop;
    assign start   = (r_state == B_IDLE) && !i_q_empty;
    assign emit    = (r_state == B_DIG) && !take && out_can;
    assign is_last = (r_pos == r_r - CNT_W'(1));
    assign o_q_pop = start;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (start) n_state = i_job.err ? B_ERR : B_BUILD;
            B_BUILD: if (r_k == '0) n_state = B_READ;
            B_READ:  n_state = B_DIG;
            B_DIG:   if (emit) n_state = is_last ? B_IDLE : B_READ;
            B_ERR:   if (out_can) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit || (r_state == B_ERR && out_can)) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // block-count table: entry k is the number of permutations per digit at position k
    always_ff @(posedge i_clk) begin
        if (r_state == B_BUILD) r_blk_mem[r_k] <= r_acc;
        if (r_state == B_READ)  r_blk <= r_blk_mem[r_pos[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (start) begin
                    r_n   <= i_job.n;
                    r_r   <= i_job.r;
                    r_rem <= i_job.rank;
                    r_acc <= RANK_W'(1);
                    r_k   <= IDX_W'(i_job.r - CNT_W'(1));
                    r_pos <= '0;
                    for (int i = 0; i < MAX_SET; i++) r_list[i] <= CNT_W'(i);
                end
            end
            B_BUILD: begin
                r_acc <= prod[RANK_W-1:0];
                r_k   <= r_k - IDX_W'(1);
            end
            B_READ: begin
                r_digit <= '0;
            end
            B_DIG: begin
                if (take) begin
                    r_rem   <= r_rem - r_blk;
                    r_digit <= r_digit + IDX_W'(1);
                end else if (emit) begin
                    r_pos <= r_pos + CNT_W'(1);
                    for (int i = 0; i < MAX_SET - 1; i++) begin
                        if (IDX_W'(i) >= r_digit) r_list[i] <= r_list[i+1];
                    end
                end
            end
            B_ERR: ;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_elem <= r_list[r_digit];
            r_opos <= r_pos;
            r_last <= is_last;
            r_err  <= 1'b0;
        end else if (r_state == B_ERR && out_can) begin
            r_elem <= '0;
            r_opos <= '0;
            r_last <= 1'b1;
            r_err  <= 1'b1;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_element     = r_elem;
    assign o_position    = r_opos;
    assign o_last        = r_last;
    assign o_range_error = r_err;

endmodule

// ----- sv/permutation_unranking.sv -----
// permutation_unranking: lexicographic r-permutation unranking of {0..n-1}.
// Front (pu_front) classifies each rank; back (pu_back) extracts the digits with a
// one-subtract-per-cycle digit search.
// Reset (synchronous, i_rst_n low) empties queue and output; set_size, pick_length = 20.
module permutation_unranking import pu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input queue side
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [RANK_W-1:0]    i_rank,
    // result queue side
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [CNT_W-1:0]     o_element,
    output logic [CNT_W-1:0]     o_position,
    output logic                 o_last,
    output logic                 o_range_error
);

    logic [CNT_W-1:0] r_set_size;
    logic [CNT_W-1:0] r_pick_length;
    logic [CNT_W-1:0] eff_n;
    logic [CNT_W-1:0] eff_r;

    logic q_push, q_full, q_pop, q_empty;
    t_job f_job, b_job;

    // config registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size    <= CNT_W'(MAX_SET);
            r_pick_length <= CNT_W'(MAX_SET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SET_SIZE:    r_set_size    <= i_cfg_data;
                REG_PICK_LENGTH: r_pick_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp n to 1..MAX_SET and r to 1..n
    always_comb begin
        eff_n = r_set_size;
        if (eff_n == '0) eff_n = CNT_W'(1);
        if (eff_n > CNT_W'(MAX_SET)) eff_n = CNT_W'(MAX_SET);
        eff_r = r_pick_length;
        if (eff_r == '0) eff_r = CNT_W'(1);
        if (eff_r > eff_n) eff_r = eff_n;
    end

    // front: takes a rank, computes the total and classifies the job
    pu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_rank   (i_rank),
        .i_n      (eff_n),
        .i_r      (eff_r),
        .o_full   (o_full),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (f_job)
    );

    // decoupling queue: front may classify the next rank while back works
    pu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (b_job)
    );

    // back: digit extraction and element selection, one result per position
    pu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_job         (b_job),
        .o_q_pop       (q_pop),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_element     (o_element),
        .o_position    (o_position),
        .o_last        (o_last),
        .o_range_error (o_range_error)
    );

    // error result is a lone, zeroed, last transfer
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_range_error) |->
            (o_last && o_position == '0 && o_element == '0))
        else $error("range error result malformed");

    // normal results stay inside the permutation length
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_range_error) |-> (o_position < eff_r))
        else $error("position beyond pick length");

    // last flag marks exactly the final position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_range_error) |-> (o_last == (o_position == eff_r - CNT_W'(1))))
        else $error("last flag misplaced");

    // elements come from the set
    a_elem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_range_error) |-> (o_element < eff_n))
        else $error("element outside set");

endmodule
